@@ rtl/cda_pkg.sv @@
// Shared types, constants and calendar tables for the date add and subtract core.
package cda_pkg;

  typedef logic [4:0]         day_t;
  typedef logic [3:0]         month_t;
  typedef logic [13:0]        year_t;
  typedef logic [8:0]         doy_t;
  typedef logic signed [10:0] sdoy_t;

  typedef struct packed {
    month_t month;
    day_t   day;
  } mday_t;

  // Request type carried on tuser.
  localparam logic REQ_ADD = 1'b0;
  localparam logic REQ_SUB = 1'b1;

  localparam year_t  YEAR_MIN    = 14'd1;
  localparam year_t  YEAR_MAX    = 14'd9999;
  localparam doy_t   DAYS_COMMON = 9'd365;
  localparam doy_t   DAYS_LEAP   = 9'd366;
  localparam day_t   FEB_LEAP    = 5'd29;
  localparam month_t MONTH_FEB   = 4'd2;
  localparam month_t MONTH_DEC   = 4'd12;

  // Reciprocal of 25 scaled by 2^19; exact quotient for every 14-bit year.
  localparam logic [14:0] RECIP25     = 15'd20972;
  localparam int          RECIP_SHIFT = 19;

  function automatic doy_t year_len(input logic leap);
    year_len = leap ? DAYS_LEAP : DAYS_COMMON;
  endfunction

  function automatic day_t month_len(input month_t m, input logic leap);
    case (m)
      4'd1, 4'd3, 4'd5, 4'd7, 4'd8, 4'd10, 4'd12: month_len = 5'd31;
      4'd4, 4'd6, 4'd9, 4'd11:                     month_len = 5'd30;
      MONTH_FEB:                                   month_len = leap ? FEB_LEAP : 5'd28;
      default:                                     month_len = 5'd0;
    endcase
  endfunction

  // Days in the year before the first of month m.
  function automatic doy_t days_before(input month_t m, input logic leap);
    doy_t base;
    case (m)
      4'd1:    base = 9'd0;
      4'd2:    base = 9'd31;
      4'd3:    base = 9'd59;
      4'd4:    base = 9'd90;
      4'd5:    base = 9'd120;
      4'd6:    base = 9'd151;
      4'd7:    base = 9'd181;
      4'd8:    base = 9'd212;
      4'd9:    base = 9'd243;
      4'd10:   base = 9'd273;
      4'd11:   base = 9'd304;
      4'd12:   base = 9'd334;
      default: base = 9'd0;
    endcase
    days_before = base + ((leap && (m > MONTH_FEB)) ? 9'd1 : 9'd0);
  endfunction

endpackage

@@ rtl/calendar_date_add_subtract_core.sv @@
// Gregorian date plus or minus a day count: six-stage pipelined top level.
//
// The input channel takes one request per beat: in_tdata carries the start
// date and day count, in_tuser selects add (0) or subtract (1). The output
// channel gives one result beat per request, in order: the result date, its
// day of year and leap flag in out_tdata, and an error flag in out_tuser.
// An invalid start date or a result year outside 1 to 9999 raises the error
// flag, and all other result fields are then zero.
//
// An accepted input beat passes through six register stages (year reciprocal
// multiply, mod-25 residue and leap flags, ordinal day, day count, year
// carry, month split) to the output. One beat may enter every cycle while
// the receiver keeps up. Each stage advances when it is empty or the stage
// after it moves, so when the receiver stalls the bubbles close up and
// in_tready falls only once every stage holds a beat. Nothing is lost or
// repeated. Reset empties the pipeline; no beat is presented afterwards
// until a new request arrives.
module calendar_date_add_subtract_core
  import cda_pkg::*;
(
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [31:0] in_tdata,   // in_day, in_month, in_year, day_count
  input  logic        in_tuser,   // req_type
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [39:0] out_tdata,  // out_day, out_month, out_year, out_day_of_year,
                                  // out_leap, zero fill
  output logic        out_tuser   // bad_date
);

  // Residue of year mod 25 that marks year-2 .. year+2 as divisible by 25.
  localparam logic [4:0] R25_HIT [5] = '{5'd2, 5'd1, 5'd0, 5'd24, 5'd23};

  logic [6:1] v_r;
  logic [6:1] en;

  // Stage 1: fields and the reciprocal product of the year.
  logic        s1_req_r;
  day_t        s1_day_r;
  month_t      s1_mon_r;
  year_t       s1_year_r;
  doy_t        s1_cnt_r;
  logic [28:0] s1_prod_r;

  // Stage 2: leap flags for the five years around the start year.
  logic       s2_req_r;
  day_t       s2_day_r;
  month_t     s2_mon_r;
  year_t      s2_year_r;
  doy_t       s2_cnt_r;
  logic [4:0] s2_lp_r;
  logic       s2_yok_r;
  logic [4:0] s2_lp_nxt;

  // Stage 3: ordinal day of the start date and the date check.
  logic       s3_req_r;
  year_t      s3_year_r;
  doy_t       s3_cnt_r;
  logic [4:0] s3_lp_r;
  doy_t       s3_doy_r;
  logic       s3_bad_r;

  // Stage 4: ordinal moved by the day count.
  logic       s4_req_r;
  year_t      s4_year_r;
  logic [4:0] s4_lp_r;
  sdoy_t      s4_doy_r;
  logic       s4_bad_r;

  // Stage 5: ordinal after carrying into neighbouring years.
  year_t      s5_year_r;
  logic       s5_leap_r;
  doy_t       s5_doy_r;
  logic       s5_bad_r;

  // Stage 6: output register.
  day_t       o_day_r;
  month_t     o_mon_r;
  year_t      o_year_r;
  doy_t       o_doy_r;
  logic       o_leap_r;
  logic       o_bad_r;

  // Each stage moves when it is empty or its successor moves.
  always_comb begin
    en[6] = !v_r[6] || out_tready;
    en[5] = !v_r[5] || en[6];
    en[4] = !v_r[4] || en[5];
    en[3] = !v_r[3] || en[4];
    en[2] = !v_r[2] || en[3];
    en[1] = !v_r[1] || en[2];
  end

  assign in_tready = en[1];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v_r <= '0;
    end else begin
      if (en[1]) v_r[1] <= in_tvalid;
      if (en[2]) v_r[2] <= v_r[1];
      if (en[3]) v_r[3] <= v_r[2];
      if (en[4]) v_r[4] <= v_r[3];
      if (en[5]) v_r[5] <= v_r[4];
      if (en[6]) v_r[6] <= v_r[5];
    end
  end

  // ---------------- Stage 1 ----------------
  always_ff @(posedge clk) begin
    if (en[1]) begin
      s1_req_r  <= in_tuser;
      s1_day_r  <= in_tdata[4:0];
      s1_mon_r  <= in_tdata[8:5];
      s1_year_r <= in_tdata[22:9];
      s1_cnt_r  <= in_tdata[31:23];
      s1_prod_r <= in_tdata[22:9] * RECIP25;
    end
  end

  // ---------------- Stage 2 ----------------
  logic [9:0] s2_q;
  year_t      s2_q25;
  year_t      s2_rem;
  logic [4:0] s2_r;

  always_comb begin
    logic [3:0] lo4;
    logic       d25;
    s2_q   = s1_prod_r[28:RECIP_SHIFT];
    s2_q25 = {s2_q, 4'b0} + {1'b0, s2_q, 3'b0} + {4'b0, s2_q};
    s2_rem = s1_year_r - s2_q25;
    s2_r   = s2_rem[4:0];
    // Leap when divisible by 4, and by 16 as well where divisible by 25.
    for (int i = 0; i < 5; i++) begin
      lo4          = s1_year_r[3:0] + 4'(i) - 4'd2;
      d25          = (s2_r == R25_HIT[i]);
      s2_lp_nxt[i] = (lo4[1:0] == 2'd0) && (!d25 || (lo4 == 4'd0));
    end
  end

  always_ff @(posedge clk) begin
    if (en[2]) begin
      s2_req_r  <= s1_req_r;
      s2_day_r  <= s1_day_r;
      s2_mon_r  <= s1_mon_r;
      s2_year_r <= s1_year_r;
      s2_cnt_r  <= s1_cnt_r;
      s2_lp_r   <= s2_lp_nxt;
      s2_yok_r  <= (s1_year_r >= YEAR_MIN) && (s1_year_r <= YEAR_MAX);
    end
  end

  // ---------------- Stage 3 ----------------
  logic s3_bad_nxt;
  doy_t s3_doy_nxt;

  always_comb begin
    s3_bad_nxt = !s2_yok_r || (s2_mon_r == 4'd0) || (s2_mon_r > MONTH_DEC) ||
                 (s2_day_r == 5'd0) || (s2_day_r > month_len(s2_mon_r, s2_lp_r[2]));
    s3_doy_nxt = {4'b0, s2_day_r} + days_before(s2_mon_r, s2_lp_r[2]);
  end

  always_ff @(posedge clk) begin
    if (en[3]) begin
      s3_req_r  <= s2_req_r;
      s3_year_r <= s2_year_r;
      s3_cnt_r  <= s2_cnt_r;
      s3_lp_r   <= s2_lp_r;
      s3_doy_r  <= s3_doy_nxt;
      s3_bad_r  <= s3_bad_nxt;
    end
  end

  // ---------------- Stage 4 ----------------
  sdoy_t s4_doy_nxt;

  always_comb begin
    if (s3_req_r == REQ_SUB) begin
      s4_doy_nxt = $signed({2'b00, s3_doy_r}) - $signed({2'b00, s3_cnt_r});
    end else begin
      s4_doy_nxt = $signed({2'b00, s3_doy_r}) + $signed({2'b00, s3_cnt_r});
    end
  end

  always_ff @(posedge clk) begin
    if (en[4]) begin
      s4_req_r  <= s3_req_r;
      s4_year_r <= s3_year_r;
      s4_lp_r   <= s3_lp_r;
      s4_doy_r  <= s4_doy_nxt;
      s4_bad_r  <= s3_bad_r;
    end
  end

  // ---------------- Stage 5 ----------------
  // At most two year boundaries can be crossed; both are tested in parallel.
  sdoy_t      s5_l0, s5_l1, s5_lm1, s5_lm2;
  logic       s5_c1, s5_c2;
  logic [1:0] s5_cnt;
  sdoy_t      s5_doy_s;
  logic [2:0] s5_idx;
  logic [14:0] s5_ysum;
  year_t      s5_year_nxt;
  logic       s5_bad_nxt;

  always_comb begin
    s5_l0  = $signed({2'b00, year_len(s4_lp_r[2])});
    s5_l1  = $signed({2'b00, year_len(s4_lp_r[3])});
    s5_lm1 = $signed({2'b00, year_len(s4_lp_r[1])});
    s5_lm2 = $signed({2'b00, year_len(s4_lp_r[0])});
    s5_ysum = 15'd0;
    if (s4_req_r == REQ_ADD) begin
      s5_c1 = s4_doy_r > s5_l0;
      s5_c2 = s4_doy_r > (s5_l0 + s5_l1);
      if (s5_c2) begin
        s5_doy_s = s4_doy_r - s5_l0 - s5_l1;
      end else if (s5_c1) begin
        s5_doy_s = s4_doy_r - s5_l0;
      end else begin
        s5_doy_s = s4_doy_r;
      end
      s5_cnt      = {1'b0, s5_c1} + {1'b0, s5_c2};
      s5_idx      = 3'd2 + {1'b0, s5_cnt};
      s5_ysum     = {1'b0, s4_year_r} + {13'b0, s5_cnt};
      s5_year_nxt = s5_ysum[13:0];
      s5_bad_nxt  = s4_bad_r || (s5_ysum > {1'b0, YEAR_MAX});
    end else begin
      s5_c1 = s4_doy_r < 11'sd1;
      s5_c2 = (s4_doy_r + s5_lm1) < 11'sd1;
      if (s5_c2) begin
        s5_doy_s = s4_doy_r + s5_lm1 + s5_lm2;
      end else if (s5_c1) begin
        s5_doy_s = s4_doy_r + s5_lm1;
      end else begin
        s5_doy_s = s4_doy_r;
      end
      s5_cnt      = {1'b0, s5_c1} + {1'b0, s5_c2};
      s5_idx      = 3'd2 - {1'b0, s5_cnt};
      s5_year_nxt = s4_year_r - {12'b0, s5_cnt};
      s5_bad_nxt  = s4_bad_r || (s4_year_r <= {12'b0, s5_cnt});
    end
  end

  always_ff @(posedge clk) begin
    if (en[5]) begin
      s5_year_r <= s5_year_nxt;
      s5_leap_r <= s4_lp_r[s5_idx];
      s5_doy_r  <= s5_doy_s[8:0];
      s5_bad_r  <= s5_bad_nxt;
    end
  end

  // ---------------- Stage 6 ----------------
  mday_t s6_md;

  cda_month_split u_split (
    .doy  (s5_doy_r),
    .leap (s5_leap_r),
    .md   (s6_md)
  );

  always_ff @(posedge clk) begin
    if (en[6]) begin
      o_bad_r <= s5_bad_r;
      if (s5_bad_r) begin
        o_day_r  <= '0;
        o_mon_r  <= '0;
        o_year_r <= '0;
        o_doy_r  <= '0;
        o_leap_r <= 1'b0;
      end else begin
        o_day_r  <= s6_md.day;
        o_mon_r  <= s6_md.month;
        o_year_r <= s5_year_r;
        o_doy_r  <= s5_doy_r;
        o_leap_r <= s5_leap_r;
      end
    end
  end

  assign out_tvalid = v_r[6];
  assign out_tdata  = {7'b0, o_leap_r, o_doy_r, o_year_r, o_mon_r, o_day_r};
  assign out_tuser  = o_bad_r;

  // ---------------- Assertions ----------------
  a_bad_zero: assert property (@(posedge clk) disable iff (!rst_n)
    (out_tvalid && out_tuser) |-> (out_tdata == 40'd0))
    else $error("error beat carries non-zero result fields");

  a_good_ranges: assert property (@(posedge clk) disable iff (!rst_n)
    (out_tvalid && !out_tuser) |->
      (out_tdata[31:23] != 9'd0) && (out_tdata[31:23] <= DAYS_LEAP) &&
      (out_tdata[8:5] != 4'd0) && (out_tdata[8:5] <= MONTH_DEC) &&
      (out_tdata[4:0] != 5'd0))
    else $error("result date fields out of range");

  a_leap_day: assert property (@(posedge clk) disable iff (!rst_n)
    (out_tvalid && !out_tuser && !out_tdata[32]) |-> (out_tdata[31:23] != DAYS_LEAP))
    else $error("day 366 in a common year");

  a_year_range: assert property (@(posedge clk) disable iff (!rst_n)
    (out_tvalid && !out_tuser) |->
      (out_tdata[22:9] >= YEAR_MIN) && (out_tdata[22:9] <= YEAR_MAX))
    else $error("result year out of range without error flag");

endmodule

@@ rtl/cda_month_split.sv @@
// Splits an ordinal day of year into month and day of month.
module cda_month_split
  import cda_pkg::*;
(
  input  doy_t  doy,
  input  logic  leap,
  output mday_t md
);

  logic [3:0] past;
  month_t     mon;
  doy_t       rem;

  // Every month end below the ordinal moves the result one month on.
  always_comb begin
    past = 4'd0;
    for (int j = 1; j < 12; j++) begin
      if (doy > days_before(month_t'(j + 1), leap)) begin
        past = past + 4'd1;
      end
    end
    mon      = past + 4'd1;
    rem      = doy - days_before(mon, leap);
    md.month = mon;
    md.day   = rem[4:0];
  end

endmodule

@@ tb/tb_top.sv @@
// Self-checking stream testbench for the calendar date add and subtract core.
`timescale 1ns / 100ps

module tb_top
  import cda_pkg::*;
();

  localparam int   RANDOM_REQS = 1400;
  localparam int   HOLD_CYCLES = 200;
  localparam int   HOLD_AT     = 600;
  localparam int   CALM_FROM   = 300;
  localparam int   CALM_TO     = 450;
  localparam int   IDLE_PCT    = 36;
  localparam int   DRAIN_WAIT  = 20;

  typedef struct packed {
    logic   sub;
    day_t   day;
    month_t month;
    year_t  year;
    doy_t   count;
  } date_req_t;

  typedef struct packed {
    day_t   day;
    month_t month;
    year_t  year;
    doy_t   doy;
    logic   leap;
    logic   bad;
  } date_res_t;

  logic        clk        = 1'b0;
  logic        rst_n      = 1'b0;
  logic        in_tvalid  = 1'b0;
  logic        in_tready;
  logic [31:0] in_tdata   = '0;  // in_day, in_month, in_year, day_count
  logic        in_tuser   = 1'b0; // req_type
  logic        out_tvalid;
  logic        out_tready = 1'b0;
  logic [39:0] out_tdata;        // out_day, out_month, out_year, out_day_of_year,
                                 // out_leap, zero fill
  logic        out_tuser;        // bad_date

  date_req_t pending_reqs[$];
  date_res_t due_dates[$];
  int        accepted_cnt = 0;
  int        fault_cnt    = 0;
  int        hold_cnt     = 0;
  logic      hold_done    = 1'b0;
  logic      calm;

  calendar_date_add_subtract_core dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tuser  (out_tuser)
  );

  always #4 clk = ~clk;

  // Neither side idles while this window of accepted beats is passing.
  assign calm = (accepted_cnt >= CALM_FROM) && (accepted_cnt < CALM_TO);

  function automatic bit leap_year(input int y);
    return ((y % 400) == 0) || (((y % 4) == 0) && ((y % 100) != 0));
  endfunction

  function automatic int days_in_year(input int y);
    return leap_year(y) ? 366 : 365;
  endfunction

  function automatic int days_in_month(input int m, input int y);
    case (m)
      2:          return leap_year(y) ? 29 : 28;
      4, 6, 9, 11: return 30;
      default:    return 31;
    endcase
  endfunction

  function automatic date_res_t shift_date(input date_req_t q);
    int        d, m, y, n, doy, k, i, rem, mo;
    bit        bad;
    date_res_t r;
    r     = '0;
    r.bad = 1'b1;
    d     = q.day;
    m     = q.month;
    y     = q.year;
    n     = q.count;
    bad   = 1'b0;
    if (m < 1 || m > 12 || y < 1 || y > 9999 || d < 1 || d > days_in_month(m, y))
      return r;
    doy = d;
    for (i = 1; i < m; i++)
      doy += days_in_month(i, y);
    if (q.sub == REQ_ADD) begin
      doy += n;
      for (k = 0; k < 3 && doy > days_in_year(y); k++) begin
        doy -= days_in_year(y);
        y++;
        if (y > 9999) begin
          bad = 1'b1;
          break;
        end
      end
    end else begin
      doy -= n;
      for (k = 0; k < 3 && doy < 1; k++) begin
        y--;
        if (y < 1) begin
          bad = 1'b1;
          break;
        end
        doy += days_in_year(y);
      end
    end
    if (bad)
      return r;
    rem = doy;
    mo  = 1;
    while (mo < 12 && rem > days_in_month(mo, y)) begin
      rem -= days_in_month(mo, y);
      mo++;
    end
    r.day   = rem[4:0];
    r.month = mo[3:0];
    r.year  = y[13:0];
    r.doy   = doy[8:0];
    r.leap  = leap_year(y);
    r.bad   = 1'b0;
    return r;
  endfunction

  function automatic date_req_t make_req(input logic sub, input int d, input int m,
                                         input int y, input int n);
    date_req_t q;
    q.sub   = sub;
    q.day   = d[4:0];
    q.month = m[3:0];
    q.year  = y[13:0];
    q.count = n[8:0];
    return q;
  endfunction

  // Mostly well-formed dates with the years and month ends weighted up; the
  // rest is raw noise over the full field widths.
  function automatic date_req_t random_req();
    int pick, d, m, y, n;
    date_req_t q;
    pick = $urandom_range(0, 99);
    if (pick < 80) begin
      m = $urandom_range(1, 12);
      case ($urandom_range(0, 4))
        0:       y = $urandom_range(1, 3);
        1:       y = $urandom_range(9997, 9999);
        default: y = $urandom_range(1, 9999);
      endcase
      d = ($urandom_range(0, 3) == 0) ? days_in_month(m, y)
                                      : $urandom_range(1, days_in_month(m, y));
      n = ($urandom_range(0, 99) < 85) ? $urandom_range(0, 365) : $urandom_range(0, 511);
      q = make_req(1'($urandom_range(0, 1)), d, m, y, n);
    end else begin
      q = make_req(1'($urandom_range(0, 1)), $urandom_range(0, 31), $urandom_range(0, 15),
                   $urandom_range(0, 16383), $urandom_range(0, 511));
    end
    return q;
  endfunction

  task automatic report_fault(input string what, input date_res_t want,
                              input date_res_t got);
    if (fault_cnt < 10) begin
      $display("%s: expected d=%0d m=%0d y=%0d doy=%0d leap=%0b bad=%0b,",
               what, want.day, want.month, want.year, want.doy, want.leap, want.bad);
      $display("  got d=%0d m=%0d y=%0d doy=%0d leap=%0b bad=%0b",
               got.day, got.month, got.year, got.doy, got.leap, got.bad);
    end
    fault_cnt++;
  endtask

  // Sender: a new beat is loaded only once the current one has gone.
  always @(posedge clk) begin : send_reqs
    date_req_t q;
    if (!rst_n) begin
      in_tvalid <= 1'b0;
    end else begin
      if (in_tvalid && in_tready) begin
        q.sub   = in_tuser;
        q.day   = in_tdata[4:0];
        q.month = in_tdata[8:5];
        q.year  = in_tdata[22:9];
        q.count = in_tdata[31:23];
        due_dates.push_back(shift_date(q));
        accepted_cnt <= accepted_cnt + 1;
      end
      if (!in_tvalid || in_tready) begin
        if (pending_reqs.size() != 0 && (calm || $urandom_range(0, 99) >= IDLE_PCT)) begin
          q = pending_reqs.pop_front();
          in_tdata  <= {q.count, q.year, q.month, q.day};
          in_tuser  <= q.sub;
          in_tvalid <= 1'b1;
        end else begin
          in_tvalid <= 1'b0;
        end
      end
    end
  end

  // Receiver: random stalls, plus one long hold-off that fills the pipeline.
  always @(posedge clk) begin : take_results
    if (!rst_n) begin
      out_tready <= 1'b0;
      hold_cnt   <= 0;
      hold_done  <= 1'b0;
    end else if (hold_cnt != 0) begin
      out_tready <= 1'b0;
      hold_cnt   <= hold_cnt - 1;
    end else if (!hold_done && accepted_cnt >= HOLD_AT) begin
      out_tready <= 1'b0;
      hold_cnt   <= HOLD_CYCLES - 1;
      hold_done  <= 1'b1;
    end else begin
      out_tready <= calm || ($urandom_range(0, 99) >= IDLE_PCT);
    end
  end

  always @(posedge clk) begin : check_results
    date_res_t got;
    date_res_t want;
    if (rst_n && out_tvalid && out_tready) begin
      got.day   = out_tdata[4:0];
      got.month = out_tdata[8:5];
      got.year  = out_tdata[22:9];
      got.doy   = out_tdata[31:23];
      got.leap  = out_tdata[32];
      got.bad   = out_tuser;
      if (due_dates.size() == 0) begin
        report_fault("unexpected result beat", '0, got);
      end else begin
        want = due_dates.pop_front();
        if (got.day !== want.day || got.month !== want.month || got.year !== want.year ||
            got.doy !== want.doy || got.leap !== want.leap || got.bad !== want.bad)
          report_fault("result mismatch", want, got);
      end
    end
  end

  initial begin : stimulus
    int i;
    // Zero count, year edges and the carries across them.
    pending_reqs.push_back(make_req(REQ_ADD, 1, 1, 1, 0));
    pending_reqs.push_back(make_req(REQ_SUB, 15, 6, 5000, 0));
    pending_reqs.push_back(make_req(REQ_ADD, 31, 12, 2024, 0));
    pending_reqs.push_back(make_req(REQ_ADD, 31, 12, 9999, 365));
    pending_reqs.push_back(make_req(REQ_ADD, 31, 12, 9999, 1));
    pending_reqs.push_back(make_req(REQ_SUB, 1, 1, 1, 1));
    pending_reqs.push_back(make_req(REQ_SUB, 1, 1, 2, 511));
    pending_reqs.push_back(make_req(REQ_SUB, 1, 1, 3, 511));
    pending_reqs.push_back(make_req(REQ_ADD, 31, 12, 9997, 511));
    // Leap rule: ordinary leap year, plain century, four-hundredth century.
    pending_reqs.push_back(make_req(REQ_ADD, 28, 2, 2024, 1));
    pending_reqs.push_back(make_req(REQ_ADD, 28, 2, 1900, 1));
    pending_reqs.push_back(make_req(REQ_ADD, 28, 2, 2000, 1));
    pending_reqs.push_back(make_req(REQ_SUB, 29, 2, 2000, 365));
    pending_reqs.push_back(make_req(REQ_ADD, 31, 12, 2023, 365));
    pending_reqs.push_back(make_req(REQ_ADD, 1, 1, 2024, 366));
    pending_reqs.push_back(make_req(REQ_SUB, 31, 12, 2024, 365));
    // Invalid start dates.
    pending_reqs.push_back(make_req(REQ_ADD, 29, 2, 2023, 5));
    pending_reqs.push_back(make_req(REQ_ADD, 0, 5, 2020, 5));
    pending_reqs.push_back(make_req(REQ_ADD, 10, 0, 2020, 5));
    pending_reqs.push_back(make_req(REQ_SUB, 10, 13, 2020, 5));
    pending_reqs.push_back(make_req(REQ_ADD, 31, 4, 2020, 5));
    pending_reqs.push_back(make_req(REQ_ADD, 1, 1, 0, 5));
    pending_reqs.push_back(make_req(REQ_SUB, 31, 15, 16383, 511));
    for (i = 0; i < RANDOM_REQS; i++)
      pending_reqs.push_back(random_req());

    repeat (6) @(posedge clk);
    rst_n <= 1'b1;

    while (pending_reqs.size() != 0 || in_tvalid)
      @(posedge clk);
    while (due_dates.size() != 0)
      @(posedge clk);
    repeat (DRAIN_WAIT) @(posedge clk);

    if (fault_cnt == 0)
      $display("TB_OK");
    else
      $display("TB_ERROR");
    $finish;
  end

  initial begin : watchdog
    #2000000;
    $display("TB_ERROR");
    $finish;
  end

endmodule
